/* rtl/rpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangular/polar converter package
// Shared constants, the arctangent table, the stage record and helpers.
// ----------------------------------------------------------------------------
package rpc_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int FRACTION_BITS = 16;
	localparam int ATAN_LEN      = 24;
	localparam int ROOT_STAGES   = 32;
	localparam int VEC_SHIFT     = 16;

	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	localparam logic signed [36:0] PI_Q32      = 37'((PI_Q60 + (64'd1 << 27)) >> 28);
	localparam logic signed [36:0] HALF_PI_Q32 = 37'((PI_Q60 + (64'd1 << 28)) >> 29);

	localparam logic [34:0] DEG_TO_RAD_Q40 = 35'((PI_Q60 / 64'd180 + (64'd1 << 19)) >> 20);
	localparam logic [17:0] DEG_HI = 18'(DEG_TO_RAD_Q40 >> 17);
	localparam logic [16:0] DEG_LO = DEG_TO_RAD_Q40[16:0];

	localparam logic signed [33:0] FULL_DEG = 34'(360) <<< FRACTION_BITS;
	localparam logic signed [33:0] HALF_DEG = 34'(180) <<< FRACTION_BITS;

	localparam logic signed [49:0] GAIN_Q30 = 50'(652032874);

	localparam logic [31:0] ATAN_Q32 [ATAN_LEN] = '{
		32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
		32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
		32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
		32'd1048576,    32'd524288,     32'd262144,     32'd131072,
		32'd65536,      32'd32768,      32'd16384,      32'd8192,
		32'd4096,       32'd2048,       32'd1024,       32'd512
	};

	// One record per iteration stage: root extraction and CORDIC run side by side.
	typedef struct packed {
		logic                cmd;
		logic                negx;
		logic                base_neg;
		logic                zero;
		logic                flip;
		logic signed [31:0]  a;
		logic signed [24:0]  b;
		logic signed [18:0]  ang_p;
		logic [63:0]         rem;
		logic [63:0]         root;
		logic signed [49:0]  vx;
		logic signed [49:0]  vy;
		logic signed [36:0]  vz;
	} it_t;

	// Clamp a Q.32 angle to [-pi, pi] and round it to the output fraction.
	function automatic logic signed [18:0] rad_out(input logic signed [36:0] z);
		logic signed [36:0] c;
		c = z;
		if (c > PI_Q32) c = PI_Q32;
		if (c < -PI_Q32) c = -PI_Q32;
		c = c + (37'sd1 <<< (31 - FRACTION_BITS));
		return 19'(c >>> (32 - FRACTION_BITS));
	endfunction

	// Round a Q30 product and saturate it to the signed 32-bit range.
	function automatic logic signed [31:0] round_sat(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = (p + (64'sd1 <<< 29)) >>> 30;
		if (t > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (t < -64'sd2147483648) return 32'sh80000000;
		return 32'(t);
	endfunction

endpackage

/* rtl/rect_polar_convert_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangular/polar vector converter
// Pipelined root extraction and shared CORDIC giving x, y, magnitude, angle.
// ----------------------------------------------------------------------------
// Usage
//   An input beat carries command, first_value and second_value. With command
//   low the pair is (x, y); the block passes x and y through, extracts the
//   integer root of x*x + y*y and finds the angle with a vectoring CORDIC.
//   With command high the pair is (magnitude, degrees); the degrees are
//   wrapped into [-180, 180], turned into radians, and a rotation CORDIC
//   gives cosine and sine, which are scaled by the magnitude.
//   Every beat gives exactly one output beat carrying all four forms.
// Pipeline depth and throughput
//   One beat per cycle sustained while the receiver takes each result.
//   The latency is set by the root extraction, one result bit per stage over
//   32 stages; the CORDIC micro-rotations share those stages.
// Reset and stalls
//   Reset clears the stage valid bits only; the pipeline is empty afterwards.
//   When the receiver holds result_ready low with a result waiting, the whole
//   pipeline freezes and item_ready falls; nothing is lost or repeated, and
//   beats resume as soon as the result is taken.
// ----------------------------------------------------------------------------
module rect_polar_convert_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [0:0]          command,
	input  logic signed [31:0]  first_value,
	input  logic signed [24:0]  second_value,
	output logic                result_valid,
	input  logic                result_ready,
	output logic signed [31:0]  x_out,
	output logic signed [31:0]  y_out,
	output logic [31:0]         magnitude_out,
	output logic signed [18:0]  angle_out
);

	localparam int NI = rpc_pkg::ROOT_STAGES;

	logic en;
	logic v_s1, v_s2, v_s3, v_s37, v_s38;
	logic v_it [0:NI];

	// Stage 1 registers.
	logic               cmd_s1, negx_s1, bneg_s1, zero_s1;
	logic signed [31:0] a_s1;
	logic signed [24:0] b_s1;
	logic [63:0]        sqa_s1;
	logic [48:0]        sqb_s1;
	logic signed [24:0] d_s1;
	logic signed [32:0] xv_s1;
	logic signed [25:0] yv_s1;

	// Stage 2 registers.
	logic               cmd_s2, negx_s2, bneg_s2, zero_s2;
	logic signed [31:0] a_s2;
	logic signed [24:0] b_s2;
	logic [63:0]        sum_s2;
	logic signed [43:0] phi_s2;
	logic signed [42:0] plo_s2;
	logic signed [32:0] xv_s2;
	logic signed [25:0] yv_s2;

	// Stage 3 registers.
	logic               cmd_s3, negx_s3, bneg_s3, zero_s3;
	logic signed [31:0] a_s3;
	logic signed [24:0] b_s3;
	logic [63:0]        sum_s3;
	logic signed [36:0] zr_s3;
	logic signed [32:0] xv_s3;
	logic signed [25:0] yv_s3;

	// Iteration stages: element 0 is stage 4, element NI is stage 36.
	rpc_pkg::it_t iter_s [0:NI];

	// Stage 37 registers.
	logic               cmd_s37;
	logic signed [31:0] a_s37;
	logic signed [24:0] b_s37;
	logic signed [18:0] angp_s37;
	logic [31:0]        root_s37;
	logic signed [36:0] zs_s37;
	logic signed [63:0] px_s37, py_s37;

	// Stage 38 registers drive the output ports.
	logic signed [31:0] x_s38, y_s38;
	logic [31:0]        mag_s38;
	logic signed [18:0] ang_s38;

	// The whole pipeline moves together unless a result is waiting.
	assign en         = !v_s38 || result_ready;
	assign item_ready = en;

	// ---------------- stage 1: squares, degree wrap, vector fold -----------
	logic signed [63:0] sqa_c;
	logic signed [49:0] sqb_c;
	logic signed [25:0] dw_c;

	always_comb begin
		sqa_c = first_value * first_value;
		sqb_c = second_value * second_value;
		dw_c  = 26'(second_value);
		if (dw_c > rpc_pkg::HALF_DEG) begin
			dw_c = 26'(dw_c - rpc_pkg::FULL_DEG);
		end else if (dw_c < -rpc_pkg::HALF_DEG) begin
			dw_c = 26'(dw_c + rpc_pkg::FULL_DEG);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= command[0];
			// In polar mode a negative magnitude counts as zero.
			a_s1    <= (command[0] && first_value < 0) ? 32'sd0 : first_value;
			b_s1    <= second_value;
			sqa_s1  <= $unsigned(sqa_c);
			sqb_s1  <= sqb_c[48:0];
			d_s1    <= dw_c[24:0];
			negx_s1 <= first_value < 0;
			bneg_s1 <= second_value < 0;
			zero_s1 <= (first_value == 32'sd0) && (second_value == 25'sd0);
			xv_s1   <= (first_value < 0) ? -33'(first_value) : 33'(first_value);
			yv_s1   <= (first_value < 0) ? -26'(second_value) : 26'(second_value);
		end
	end

	// ---------------- stage 2: sum of squares, degree products -------------
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2  <= cmd_s1;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			negx_s2 <= negx_s1;
			bneg_s2 <= bneg_s1;
			zero_s2 <= zero_s1;
			xv_s2   <= xv_s1;
			yv_s2   <= yv_s1;
			sum_s2  <= sqa_s1 + {15'd0, sqb_s1};
			phi_s2  <= 44'(d_s1) * $signed({26'd0, rpc_pkg::DEG_HI});
			plo_s2  <= 43'(d_s1) * $signed({26'd0, rpc_pkg::DEG_LO});
		end
	end

	// ---------------- stage 3: degrees to Q.32 radians ---------------------
	logic signed [61:0] zp_c;

	always_comb begin
		zp_c = (62'(phi_s2) <<< 17) + 62'(plo_s2)
			+ (62'sd1 <<< (7 + rpc_pkg::FRACTION_BITS));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3  <= cmd_s2;
			a_s3    <= a_s2;
			b_s3    <= b_s2;
			negx_s3 <= negx_s2;
			bneg_s3 <= bneg_s2;
			zero_s3 <= zero_s2;
			xv_s3   <= xv_s2;
			yv_s3   <= yv_s2;
			sum_s3  <= sum_s2;
			zr_s3   <= 37'(zp_c >>> (8 + rpc_pkg::FRACTION_BITS));
		end
	end

	// ---------------- stage 4: quadrant fold and iteration set-up ----------
	rpc_pkg::it_t init_c;

	always_comb begin
		init_c          = '0;
		init_c.cmd      = cmd_s3;
		init_c.negx     = negx_s3;
		init_c.base_neg = bneg_s3;
		init_c.zero     = zero_s3;
		init_c.a        = a_s3;
		init_c.b        = b_s3;
		init_c.ang_p    = rpc_pkg::rad_out(zr_s3);
		init_c.rem      = sum_s3;
		init_c.root     = 64'd0;
		if (cmd_s3) begin
			// Rotation starts from the gain-corrected unit vector.
			init_c.vx = rpc_pkg::GAIN_Q30;
			init_c.vy = 50'sd0;
			init_c.vz = zr_s3;
			if (zr_s3 > rpc_pkg::HALF_PI_Q32) begin
				init_c.vz   = zr_s3 - rpc_pkg::PI_Q32;
				init_c.flip = 1'b1;
			end else if (zr_s3 < -rpc_pkg::HALF_PI_Q32) begin
				init_c.vz   = zr_s3 + rpc_pkg::PI_Q32;
				init_c.flip = 1'b1;
			end
		end else begin
			// Vectoring works on the right half-plane vector, scaled up.
			init_c.vx = 50'(xv_s3) <<< rpc_pkg::VEC_SHIFT;
			init_c.vy = 50'(yv_s3) <<< rpc_pkg::VEC_SHIFT;
			init_c.vz = 37'sd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			iter_s[0] <= init_c;
		end
	end

	// ---------------- stages 5 to 36: root bit and micro-rotation ----------
	for (genvar k = 0; k < NI; k++) begin : g_iter
		localparam logic [63:0] RBIT = 64'd1 << (62 - 2 * k);

		rpc_pkg::it_t nxt;
		logic [63:0]  trial;

		if (k < rpc_pkg::CORDIC_STAGES) begin : g_rot
			localparam logic signed [36:0] AT = 37'(rpc_pkg::ATAN_Q32[k]);

			logic               dir;
			logic signed [49:0] dx, dy;

			always_comb begin
				nxt   = iter_s[k];
				trial = iter_s[k].root + RBIT;
				if (iter_s[k].rem >= trial) begin
					nxt.rem  = iter_s[k].rem - trial;
					nxt.root = (iter_s[k].root >> 1) + RBIT;
				end else begin
					nxt.root = iter_s[k].root >> 1;
				end
				// Vectoring drives y to zero, rotation drives z to zero;
				// both then share one update.
				dir = iter_s[k].cmd ? (iter_s[k].vz >= 0) : (iter_s[k].vy < 0);
				dx  = iter_s[k].vy >>> k;
				dy  = iter_s[k].vx >>> k;
				if (dir) begin
					nxt.vx = iter_s[k].vx - dx;
					nxt.vy = iter_s[k].vy + dy;
					nxt.vz = iter_s[k].vz - AT;
				end else begin
					nxt.vx = iter_s[k].vx + dx;
					nxt.vy = iter_s[k].vy - dy;
					nxt.vz = iter_s[k].vz + AT;
				end
			end
		end else begin : g_root
			always_comb begin
				nxt   = iter_s[k];
				trial = iter_s[k].root + RBIT;
				if (iter_s[k].rem >= trial) begin
					nxt.rem  = iter_s[k].rem - trial;
					nxt.root = (iter_s[k].root >> 1) + RBIT;
				end else begin
					nxt.root = iter_s[k].root >> 1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				iter_s[k + 1] <= nxt;
			end
		end
	end

	// ---------------- stage 37: angle base and polar products --------------
	rpc_pkg::it_t       fin;
	logic signed [36:0] base_c;
	logic signed [32:0] cx_c, sy_c;

	always_comb begin
		fin    = iter_s[NI];
		base_c = 37'sd0;
		if (fin.negx) begin
			base_c = fin.base_neg ? -rpc_pkg::PI_Q32 : rpc_pkg::PI_Q32;
		end
		cx_c = 33'(fin.flip ? -fin.vx : fin.vx);
		sy_c = 33'(fin.flip ? -fin.vy : fin.vy);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s37  <= fin.cmd;
			a_s37    <= fin.a;
			b_s37    <= fin.b;
			angp_s37 <= fin.ang_p;
			root_s37 <= fin.root[31:0];
			zs_s37   <= fin.zero ? 37'sd0 : fin.vz + base_c;
			px_s37   <= 64'(fin.a) * 64'(cx_c);
			py_s37   <= 64'(fin.a) * 64'(sy_c);
		end
	end

	// ---------------- stage 38: rounding, saturation, output select --------
	always_ff @(posedge clk) begin
		if (en) begin
			if (cmd_s37) begin
				x_s38   <= rpc_pkg::round_sat(px_s37);
				y_s38   <= rpc_pkg::round_sat(py_s37);
				mag_s38 <= $unsigned(a_s37);
				ang_s38 <= angp_s37;
			end else begin
				x_s38   <= a_s37;
				y_s38   <= 32'(b_s37);
				mag_s38 <= root_s37;
				ang_s38 <= rpc_pkg::rad_out(zs_s37);
			end
		end
	end

	// ---------------- valid bits -------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s37 <= 1'b0;
			v_s38 <= 1'b0;
			for (int i = 0; i <= NI; i++) begin
				v_it[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1    <= item_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_it[0] <= v_s3;
			for (int i = 0; i < NI; i++) begin
				v_it[i + 1] <= v_it[i];
			end
			v_s37 <= v_it[NI];
			v_s38 <= v_s37;
		end
	end

	assign result_valid  = v_s38;
	assign x_out         = x_s38;
	assign y_out         = y_s38;
	assign magnitude_out = mag_s38;
	assign angle_out     = ang_s38;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangular/polar converter testbench
// Drives vectors in both forms through rect_polar_convert_core. A local model
// gives x, y, magnitude and angle for every beat, and each result is compared
// with it in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int STAGES    = 16;
	localparam int FRAC      = 16;
	localparam int WDOG_MAX  = 4000;
	localparam int DRAIN_CYC = 60;

	localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
	localparam longint PI_Z      = longint'((PI_Q60 + (64'd1 << 27)) >> 28);
	localparam longint HALF_PI_Z = longint'((PI_Q60 + (64'd1 << 28)) >> 29);
	localparam longint DEG_RAD   = longint'((PI_Q60 / 64'd180 + (64'd1 << 19)) >> 20);
	localparam longint UNIT_GAIN = 64'sd652032874;
	localparam longint DEG_FULL  = 64'sd360 <<< FRAC;
	localparam longint DEG_HALF  = 64'sd180 <<< FRAC;

	typedef enum logic [0:0] {CMD_RECT = 1'b0, CMD_POLAR = 1'b1} cmd_e;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [31:0]        mag;
		logic signed [18:0] ang;
	} vec_forms_t;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	logic [0:0]         command;
	logic signed [31:0] first_value;
	logic signed [24:0] second_value;
	logic               result_valid;
	logic               result_ready;
	logic signed [31:0] x_out;
	logic signed [31:0] y_out;
	logic [31:0]        magnitude_out;
	logic signed [18:0] angle_out;

	vec_forms_t expected_forms[$];
	longint     atan_z[24];
	int         mismatches;
	int         idle_cycles;
	bit         no_idle;

	rect_polar_convert_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.command      (command),
		.first_value  (first_value),
		.second_value (second_value),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.x_out        (x_out),
		.y_out        (y_out),
		.magnitude_out(magnitude_out),
		.angle_out    (angle_out)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint unsigned int_root(input longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Clamp a Q.32 angle to [-pi, pi], then round half up to the output fraction.
	function automatic logic signed [18:0] round_angle(input longint z);
		if (z > PI_Z) z = PI_Z;
		if (z < -PI_Z) z = -PI_Z;
		return 19'((z + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC));
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic vec_forms_t convert_vector(input cmd_e cmd, input longint a,
			input longint b);
		vec_forms_t r;
		longint vx, vy, z, base, dx, dy, d, c, s;
		bit flip;
		if (cmd == CMD_RECT) begin
			r.x = 32'(a);
			r.y = 32'(b);
			r.mag = 32'(int_root(longint'(a * a) + longint'(b * b)));
			z = 0;
			if (a != 0 || b != 0) begin
				base = 0;
				// Left half-plane: turn by half a circle and add pi back later.
				if (a < 0) begin
					base = (b >= 0) ? PI_Z : -PI_Z;
					a = -a;
					b = -b;
				end
				vx = a * 65536;
				vy = b * 65536;
				for (int i = 0; i < STAGES; i++) begin
					dx = vy >>> i;
					dy = vx >>> i;
					if (vy < 0) begin
						vx = vx - dx; vy = vy + dy; z = z - atan_z[i];
					end else begin
						vx = vx + dx; vy = vy - dy; z = z + atan_z[i];
					end
				end
				z = base + z;
			end
			r.ang = round_angle(z);
		end else begin
			d = b % DEG_FULL;
			if (d > DEG_HALF) d = d - DEG_FULL;
			if (d < -DEG_HALF) d = d + DEG_FULL;
			z = (d * DEG_RAD + (64'sd1 <<< (7 + FRAC))) >>> (8 + FRAC);
			r.ang = round_angle(z);
			if (a < 0) a = 0;
			flip = 1'b0;
			if (z > HALF_PI_Z) begin
				z = z - PI_Z; flip = 1'b1;
			end else if (z < -HALF_PI_Z) begin
				z = z + PI_Z; flip = 1'b1;
			end
			vx = UNIT_GAIN;
			vy = 0;
			for (int i = 0; i < STAGES; i++) begin
				dx = vy >>> i;
				dy = vx >>> i;
				if (z >= 0) begin
					vx = vx - dx; vy = vy + dy; z = z - atan_z[i];
				end else begin
					vx = vx + dx; vy = vy - dy; z = z + atan_z[i];
				end
			end
			c = flip ? -vx : vx;
			s = flip ? -vy : vy;
			r.x = 32'(clamp32((a * c + (64'sd1 <<< 29)) >>> 30));
			r.y = 32'(clamp32((a * s + (64'sd1 <<< 29)) >>> 30));
			r.mag = 32'(a);
		end
		return r;
	endfunction

	// Sends one beat after a random gap and records its expected forms.
	task automatic send_vector(input cmd_e cmd, input logic signed [31:0] a,
			input logic signed [24:0] b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		command = cmd;
		first_value = a;
		second_value = b;
		item_valid = 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		expected_forms.push_back(convert_vector(cmd, longint'(a), longint'(b)));
		@(negedge clk);
	endtask

	task automatic release_item;
		item_valid = 1'b0;
	endtask

	function automatic logic signed [24:0] rand_degrees;
		return 25'($signed($urandom_range(0, 23592960)) - 11796480);
	endfunction

	function automatic logic signed [31:0] rand_first;
		case ($urandom_range(0, 3))
			0: return $signed($urandom_range(0, 255)) - 128;
			1: return $signed($urandom_range(0, 2097151)) - 1048576;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed;
		send_vector(CMD_RECT, 0, 25'sd0);
		send_vector(CMD_RECT, 32'sh7FFFFFFF, 25'sd11796480);
		send_vector(CMD_RECT, 32'sh80000000, -25'sd11796480);
		send_vector(CMD_RECT, 32'sh80000000, 25'sd0);
		send_vector(CMD_RECT, -65536, 25'sd0);
		send_vector(CMD_RECT, -65536, -25'sd1);
		send_vector(CMD_RECT, 0, 25'sd65536);
		send_vector(CMD_RECT, 0, -25'sd65536);
		send_vector(CMD_RECT, 3 << 16, 25'(4 << 16));
		send_vector(CMD_RECT, 1, -25'sd1);
		send_vector(CMD_POLAR, 1 << 16, 25'sd0);
		send_vector(CMD_POLAR, 1 << 16, 25'(90 << 16));
		send_vector(CMD_POLAR, 1 << 16, 25'(-(90 << 16)));
		send_vector(CMD_POLAR, 1 << 16, 25'sd11796480);
		send_vector(CMD_POLAR, 1 << 16, -25'sd11796480);
		send_vector(CMD_POLAR, 32'sh7FFFFFFF, 25'(45 << 16));
		send_vector(CMD_POLAR, 32'sh7FFFFFFF, 25'(135 << 16));
		send_vector(CMD_POLAR, -5, 25'(30 << 16));
		send_vector(CMD_POLAR, 32'sh80000000, 25'(-(100 << 16)));
		send_vector(CMD_POLAR, 0, 25'sd0);
		send_vector(CMD_POLAR, 32'sh7FFFFFFF, 25'sd11796479);
		// Angles beyond a half turn either way wrap back into range.
		send_vector(CMD_POLAR, 1 << 16, 25'sh0FFFFFF);
		send_vector(CMD_POLAR, 1 << 16, 25'sh1000000);
		release_item();
	endtask

	task automatic test_random_mix(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 1))
				send_vector(CMD_POLAR, rand_first(), rand_degrees());
			else
				send_vector(CMD_RECT, rand_first(), rand_degrees());
		end
		release_item();
	endtask

	task automatic test_back_to_back(input int count);
		no_idle = 1'b1;
		test_random_mix(count);
		no_idle = 1'b0;
	endtask

	task automatic test_drain_pause;
		test_random_mix(40);
		while (expected_forms.size() != 0) @(negedge clk);
		test_random_mix(40);
	endtask

	// Receiver: random stall before each beat, none while no_idle is set.
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			stall = no_idle ? 0 : $urandom_range(0, 8);
			@(negedge clk);
			if (stall > 0) begin
				result_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready = 1'b1;
			@(posedge clk);
			while (!(result_valid && result_ready)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		vec_forms_t e;
		if (arst_n && result_valid && result_ready) begin
			if (expected_forms.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%0d y=%0d", x_out, y_out);
			end else begin
				e = expected_forms.pop_front();
				if (x_out !== e.x || y_out !== e.y || magnitude_out !== e.mag ||
						angle_out !== e.ang) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp x=%0d y=%0d m=%0d a=%0d, got %0d %0d %0d %0d",
							e.x, e.y, e.mag, e.ang, x_out, y_out, magnitude_out,
							angle_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		atan_z = '{64'd3373259426, 64'd1991351318, 64'd1052175346, 64'd534100635,
			64'd268086748, 64'd134174063, 64'd67103403, 64'd33553749,
			64'd16777131, 64'd8388597, 64'd4194303, 64'd2097152,
			64'd1048576, 64'd524288, 64'd262144, 64'd131072,
			64'd65536, 64'd32768, 64'd16384, 64'd8192,
			64'd4096, 64'd2048, 64'd1024, 64'd512};
		mismatches = 0;
		idle_cycles = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		command = CMD_RECT;
		first_value = '0;
		second_value = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random_mix(500);
		test_back_to_back(200);
		test_drain_pause();
		test_random_mix(420);
		while (expected_forms.size() != 0) @(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);
		if (mismatches == 0 && expected_forms.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
